[hw/rtl/qwspg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwspg_pkg
// Shared types and constants of the quarter-wave sine PWM generator.
// ----------------------------------------------------------------------------
package qwspg_pkg;

  localparam int unsigned DefTableDepth = 32;
  localparam int unsigned DefCountWidth = 32;

  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned CfgIndexWidth = 3;

  localparam int unsigned SampleWidth   = 16;
  localparam int unsigned TableIdxWidth = 5;
  localparam int unsigned LengthWidth   = 6;

  localparam logic [LengthWidth-1:0]  ResetTableLength = LengthWidth'(25);
  localparam logic [SampleWidth-1:0]  ResetPulseMin    = SampleWidth'(1);
  localparam logic signed [SampleWidth-1:0] SampleMaxPos = 16'sh7fff;
  localparam logic signed [SampleWidth-1:0] SampleMinNeg = 16'sh8000;

  typedef enum logic {
    OP_TICK        = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } op_e;

  typedef enum logic {
    OUT_SINGLE    = 1'b0,
    OUT_ALTERNATE = 1'b1
  } out_mode_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_TICK_PERIOD  = 3'd0,
    CFG_TABLE_LENGTH = 3'd1,
    CFG_QUARTER_MODE = 3'd2,
    CFG_OUTPUT_MODE  = 3'd3,
    CFG_PULSE_MIN    = 3'd4,
    CFG_PAUSED       = 3'd5
  } cfg_idx_e;

  // control that travels with a tick while the sample store is read
  typedef struct packed {
    logic negate;
    logic value_changed;
    logic sign_changed;
    logic sign_positive;
  } tick_ctrl_t;

endpackage

[hw/rtl/quarter_wave_sine_pwm_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quarter_wave_sine_pwm_generator_unit
// Tick-driven sine lookup with quarter-wave folding and two PWM compares.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall_o is low. A
// table write goes into the sample RAM in the cycle it is accepted and gives
// no result. A tick updates the prescale counter, sample index and quadrant
// in the cycle it is accepted and issues the sample RAM read; the read data
// and the tick's control are registered in the read stage, where the sample
// is folded and the compare values are formed, and they are loaded into the
// output register once it is free, from which the result is presented. A
// stalled result only holds off new items once the read stage behind it is
// also full. Load every table entry in use before sending ticks.
module quarter_wave_sine_pwm_generator_unit #(
  parameter int unsigned TABLE_DEPTH = qwspg_pkg::DefTableDepth,
  parameter int unsigned COUNT_WIDTH = qwspg_pkg::DefCountWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [4:0]  table_index_i,
  input  logic signed [15:0] table_value_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] sample_value_o,
  output logic        value_changed_o,
  output logic        sign_changed_o,
  output logic        sign_positive_o,
  output logic [15:0] compare_one_o,
  output logic [15:0] compare_two_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned LenW = IdxW + 1;
  localparam int unsigned CmpW = (LenW > qwspg_pkg::LengthWidth) ?
                                 LenW : qwspg_pkg::LengthWidth;
  localparam int unsigned TiW  = ((IdxW > qwspg_pkg::TableIdxWidth) ?
                                 IdxW : qwspg_pkg::TableIdxWidth) + 1;
  localparam int unsigned PerW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  // configuration
  logic [31:0]                           tick_period_q;
  logic [qwspg_pkg::LengthWidth-1:0]     table_length_q;
  logic                                  quarter_mode_q;
  logic                                  output_mode_q;
  logic [15:0]                           pulse_min_q;
  logic                                  paused_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q  <= '0;
      table_length_q <= qwspg_pkg::ResetTableLength;
      quarter_mode_q <= 1'b1;
      output_mode_q  <= qwspg_pkg::OUT_SINGLE;
      pulse_min_q    <= qwspg_pkg::ResetPulseMin;
      paused_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        qwspg_pkg::CFG_TICK_PERIOD:  tick_period_q  <= cfg_data_i;
        qwspg_pkg::CFG_TABLE_LENGTH: table_length_q <= cfg_data_i[qwspg_pkg::LengthWidth-1:0];
        qwspg_pkg::CFG_QUARTER_MODE: quarter_mode_q <= cfg_data_i[0];
        qwspg_pkg::CFG_OUTPUT_MODE:  output_mode_q  <= cfg_data_i[0];
        qwspg_pkg::CFG_PULSE_MIN:    pulse_min_q    <= cfg_data_i[15:0];
        qwspg_pkg::CFG_PAUSED:       paused_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_q, out_valid_d;
  logic s1_valid_q, s1_valid_d;
  logic out_free, s1_move, in_acc, tick_acc, wr_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (operation_i == qwspg_pkg::OP_TICK);
  assign wr_acc     = in_acc && (operation_i == qwspg_pkg::OP_TABLE_WRITE);

  // stage 0: advance counters, form the read address
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic [IdxW-1:0]        idx_q, idx_d, idx_eff, pos;
  logic [1:0]             quad_q, quad_d;
  logic [CmpW-1:0]        tl_ext, len_c;
  logic [LenW-1:0]        len, len_m1, idx_inc;
  logic                   adv, wrap;
  qwspg_pkg::tick_ctrl_t  ctrl_d, ctrl_q;

  always_comb begin
    tl_ext = CmpW'(table_length_q);
    if (tl_ext == '0) begin
      len_c = CmpW'(1);
    end else if (tl_ext > CmpW'(TABLE_DEPTH)) begin
      len_c = CmpW'(TABLE_DEPTH);
    end else begin
      len_c = tl_ext;
    end
    len    = len_c[LenW-1:0];
    len_m1 = len - LenW'(1);

    cnt_inc = paused_q ? cnt_q : cnt_q + COUNT_WIDTH'(1);
    adv     = PerW'(cnt_inc) >= PerW'(tick_period_q);
    cnt_d   = adv ? '0 : cnt_inc;

    idx_inc = LenW'(idx_q) + LenW'(1);
    wrap    = adv && (idx_inc >= len);
    if (!adv) begin
      idx_d = idx_q;
    end else if (wrap) begin
      idx_d = '0;
    end else begin
      idx_d = idx_inc[IdxW-1:0];
    end
    quad_d = wrap ? quad_q + 2'd1 : quad_q;

    idx_eff = (LenW'(idx_d) > len_m1) ? len_m1[IdxW-1:0] : idx_d;
    pos     = (quarter_mode_q && quad_d[0]) ?
              IdxW'(len_m1 - LenW'(idx_eff)) : idx_eff;

    ctrl_d.negate        = quarter_mode_q && quad_d[1];
    ctrl_d.value_changed = adv;
    ctrl_d.sign_changed  = wrap && !quad_d[0];
    ctrl_d.sign_positive = !quad_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      quad_q <= '0;
    end else if (tick_acc) begin
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      quad_q <= quad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      ctrl_q <= ctrl_d;
    end
  end

  // sample store
  logic [TiW-1:0]  ti_ext;
  logic            wr_en;
  logic [15:0]     raw_u;

  assign ti_ext = TiW'(table_index_i);
  assign wr_en  = wr_acc && (ti_ext < TiW'(TABLE_DEPTH));

  qwspg_ram #(
    .Width (qwspg_pkg::SampleWidth),
    .Depth (TABLE_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ti_ext[IdxW-1:0]),
    .wdata_i (table_value_i),
    .re_i    (tick_acc),
    .raddr_i (pos),
    .rdata_o (raw_u)
  );

  // stage 1: fold the sample, set compares
  logic signed [15:0] raw, val, val_q;
  logic signed [16:0] val_ext;
  logic [15:0]        mag;
  logic [15:0]        cmp1_q, cmp1_d, cmp2_q, cmp2_d;
  qwspg_pkg::tick_ctrl_t out_ctrl_q;

  always_comb begin
    raw = raw_u;
    if (ctrl_q.negate) begin
      val = (raw == qwspg_pkg::SampleMinNeg) ? qwspg_pkg::SampleMaxPos : -raw;
    end else begin
      val = raw;
    end
    val_ext = 17'(val);
    mag     = val[15] ? 16'(-val_ext) : 16'(val);

    cmp1_d = cmp1_q;
    cmp2_d = cmp2_q;
    if (output_mode_q == qwspg_pkg::OUT_SINGLE) begin
      cmp1_d = mag;
    end else if (!val[15]) begin
      cmp1_d = 16'(val);
      cmp2_d = pulse_min_q;
    end else begin
      cmp1_d = pulse_min_q;
      cmp2_d = mag;
    end
  end

  always_comb begin
    s1_valid_d = tick_acc ? 1'b1 : (out_free ? 1'b0 : s1_valid_q);
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cmp1_q      <= '0;
      cmp2_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_move) begin
        cmp1_q <= cmp1_d;
        cmp2_q <= cmp2_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      val_q      <= val;
      out_ctrl_q <= ctrl_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_value_o  = val_q;
  assign value_changed_o = out_ctrl_q.value_changed;
  assign sign_changed_o  = out_ctrl_q.sign_changed;
  assign sign_positive_o = out_ctrl_q.sign_positive;
  assign compare_one_o   = cmp1_q;
  assign compare_two_o   = cmp2_q;

  // checks
  a_tick_fills_read_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> s1_valid_q)
    else $error("accepted tick did not enter the read stage");

  a_read_stage_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("read stage moved but no result is shown");

  a_full_pipe_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("item taken while both stages are held");

  a_advance_clears_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && adv) |=> (cnt_q == '0))
    else $error("prescale counter not cleared on advance");

  a_index_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && adv) |=> (LenW'(idx_q) < $past(len)))
    else $error("sample index beyond table length after advance");

endmodule

[hw/rtl/qwspg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwspg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qwspg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
